>>> rtl/cfrw_pkg.sv
// Shared types, constants and register codes for the command frame receiver watchdog.
package cfrw_pkg;

  // Default geometry of a command frame.
  localparam int PAYLOAD_BYTES_DEF = 9;
  localparam int DRIBBLE_INDEX_DEF = 8;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // Register indexes, byte address is four times the index.
  localparam logic [REG_IDX_W-1:0] REG_FIRST_HDR   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_HDR  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DRIBBLE_ON  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_LIM = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DRIBBLE_SPD = 3'd4;

  // Register reset values.
  localparam logic [7:0]  FIRST_HDR_RST   = 8'd0;
  localparam logic [7:0]  SECOND_HDR_RST  = 8'd0;
  localparam logic [7:0]  DRIBBLE_ON_RST  = 8'd1;
  localparam logic [15:0] TIMEOUT_LIM_RST = 16'd100;
  localparam logic [14:0] DRIBBLE_SPD_RST = 15'd1500;

  // Saturation value of the tick counter.
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // Item kinds carried in the action field.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HDR2,
    PH_BODY
  } phase_t;

  // One input transfer.
  typedef struct packed {
    logic       action;
    logic [7:0] rx_data;
  } in_item_t;

  // One result transfer.
  typedef struct packed {
    logic signed [15:0] wheel_target_a;
    logic signed [15:0] wheel_target_b;
    logic signed [15:0] wheel_target_c;
    logic signed [15:0] wheel_target_d;
    logic [14:0]        dribble_output;
    logic               frame_done;
    logic               timed_out;
  } out_item_t;

  // Event from the parser when a byte completes a frame.
  typedef struct packed {
    logic             done;
    logic             drb_match;
    logic [3:0][15:0] targets;
  } frame_evt_t;

endpackage

>>> rtl/cfrw_parser.sv
// Header hunt, payload capture and frame decode for the command frame receiver.
module cfrw_parser
  import cfrw_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter int DRIBBLE_INDEX = DRIBBLE_INDEX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] rx_data,
  input  logic [7:0] first_hdr,
  input  logic [7:0] second_hdr,
  input  logic [7:0] dribble_on_code,
  output frame_evt_t evt
);

  localparam int CW = $clog2(PAYLOAD_BYTES);
  localparam logic [CW-1:0] LAST = CW'(PAYLOAD_BYTES - 1);

  phase_t        phase_r, phase_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          store_we;
  logic          done;
  logic [7:0]    store_r [PAYLOAD_BYTES];
  logic [7:0]    dribble_byte;

  // Phase and payload counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  // Next phase: hunt for the first header, check the second, then count payload.
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    store_we  = 1'b0;
    done      = 1'b0;
    unique case (phase_r)
      PH_HUNT: begin
        if (byte_en && rx_data == first_hdr) phase_nxt = PH_HDR2;
      end
      PH_HDR2: begin
        if (byte_en) begin
          if (rx_data == second_hdr) begin
            phase_nxt = PH_BODY;
            count_nxt = '0;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
      end
      PH_BODY: begin
        if (byte_en) begin
          store_we = 1'b1;
          if (count_r == LAST) begin
            done      = 1'b1;
            phase_nxt = PH_HUNT;
            count_nxt = '0;
          end else begin
            count_nxt = count_r + CW'(1);
          end
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        count_nxt = '0;
      end
    endcase
  end

  // Payload store, one byte per transfer in the body phase.
  always_ff @(posedge clk) begin
    if (store_we) store_r[count_r] <= rx_data;
  end

  // The dribble byte may be the byte arriving now, a stored payload byte, or lie past the payload.
  generate
    if (DRIBBLE_INDEX >= PAYLOAD_BYTES) begin : g_drb_none
      assign dribble_byte = 8'd0;
    end else if (DRIBBLE_INDEX == PAYLOAD_BYTES - 1) begin : g_drb_last
      assign dribble_byte = rx_data;
    end else begin : g_drb_store
      assign dribble_byte = store_r[DRIBBLE_INDEX];
    end
  endgenerate

  // Big-endian wheel targets from the first eight payload bytes.
  always_comb begin
    evt.done      = done;
    evt.drb_match = (dribble_byte == dribble_on_code);
    for (int k = 0; k < 4; k++) begin
      evt.targets[k] = {store_r[2*k], store_r[2*k+1]};
    end
  end

endmodule

>>> rtl/command_frame_receiver_watchdog.sv
// Top level of the command frame receiver with tick watchdog and APB-style registers.
// Each input transfer is either a received serial byte or a control tick, and each
// produces exactly one result transfer. The block takes one item per clock cycle:
// the parser, the watchdog counter and the target update are combinational and land
// in the output register, so a result appears in the cycle after its item is accepted
// and a new item is taken whenever the output register is empty or being drained in
// the same cycle. Throughput is therefore one item per cycle as long as the result
// side keeps out_ready high. The targets are zeroed on any item after which the tick
// count is at or above timeout_limit; a completed frame clears the count.
// The user must write configuration registers while the block is idle (not enforced).
module command_frame_receiver_watchdog
  import cfrw_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter int DRIBBLE_INDEX = DRIBBLE_INDEX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [7:0]       first_hdr_r;
  logic [7:0]       second_hdr_r;
  logic [7:0]       dribble_on_r;
  logic [15:0]      timeout_lim_r;
  logic [14:0]      dribble_spd_r;
  logic             cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  logic             acc;
  logic             tick;
  frame_evt_t       evt;
  logic [15:0]      ticks_r, ticks_nxt;
  logic [3:0][15:0] targets_r, targets_nxt;
  logic             dribble_r, dribble_nxt;
  logic             expired;
  logic             out_valid_r;
  out_item_t        out_data_r, out_data_nxt;

  // Configuration register writes.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_hdr_r   <= FIRST_HDR_RST;
      second_hdr_r  <= SECOND_HDR_RST;
      dribble_on_r  <= DRIBBLE_ON_RST;
      timeout_lim_r <= TIMEOUT_LIM_RST;
      dribble_spd_r <= DRIBBLE_SPD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FIRST_HDR:   first_hdr_r   <= cfg_pwdata[7:0];
        REG_SECOND_HDR:  second_hdr_r  <= cfg_pwdata[7:0];
        REG_DRIBBLE_ON:  dribble_on_r  <= cfg_pwdata[7:0];
        REG_TIMEOUT_LIM: timeout_lim_r <= cfg_pwdata[15:0];
        REG_DRIBBLE_SPD: dribble_spd_r <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (cfg_idx)
      REG_FIRST_HDR:   cfg_prdata = {24'd0, first_hdr_r};
      REG_SECOND_HDR:  cfg_prdata = {24'd0, second_hdr_r};
      REG_DRIBBLE_ON:  cfg_prdata = {24'd0, dribble_on_r};
      REG_TIMEOUT_LIM: cfg_prdata = {16'd0, timeout_lim_r};
      REG_DRIBBLE_SPD: cfg_prdata = {17'd0, dribble_spd_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // Input transfer handshake: the output register frees up as it drains.
  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign tick     = acc && (in_data.action == ACT_TICK);

  cfrw_parser #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .DRIBBLE_INDEX (DRIBBLE_INDEX)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .byte_en         (acc && (in_data.action == ACT_BYTE)),
    .rx_data         (in_data.rx_data),
    .first_hdr       (first_hdr_r),
    .second_hdr      (second_hdr_r),
    .dribble_on_code (dribble_on_r),
    .evt             (evt)
  );

  // Watchdog counter, target and dribble flag update for the accepted item.
  always_comb begin
    ticks_nxt   = ticks_r;
    targets_nxt = targets_r;
    dribble_nxt = dribble_r;
    if (evt.done) begin
      ticks_nxt   = '0;
      targets_nxt = evt.targets;
      dribble_nxt = evt.drb_match;
    end else if (tick && ticks_r != TICK_MAX) begin
      ticks_nxt = ticks_r + 16'd1;
    end
    expired = (ticks_nxt >= timeout_lim_r);
    if (expired) targets_nxt = '0;
  end

  // Result for the accepted item.
  always_comb begin
    out_data_nxt.wheel_target_a = targets_nxt[0];
    out_data_nxt.wheel_target_b = targets_nxt[1];
    out_data_nxt.wheel_target_c = targets_nxt[2];
    out_data_nxt.wheel_target_d = targets_nxt[3];
    out_data_nxt.dribble_output = dribble_nxt ? dribble_spd_r : 15'd0;
    out_data_nxt.frame_done     = evt.done;
    out_data_nxt.timed_out      = expired;
  end

  // Watchdog state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r   <= '0;
      targets_r <= '0;
      dribble_r <= 1'b0;
    end else if (acc) begin
      ticks_r   <= ticks_nxt;
      targets_r <= targets_nxt;
      dribble_r <= dribble_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A tick never completes a frame.
  a_tick_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && tick) |=> (out_valid_r && !out_data_r.frame_done))
    else $error("tick transfer reported frame_done");

  // A timed-out result always carries zero targets.
  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.timed_out) |->
      (out_data_r.wheel_target_a == 16'sd0 && out_data_r.wheel_target_b == 16'sd0 &&
       out_data_r.wheel_target_c == 16'sd0 && out_data_r.wheel_target_d == 16'sd0))
    else $error("timed-out result with nonzero targets");

  // A completed frame clears the tick counter.
  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && acc && evt.done) |=> (ticks_r == 16'd0))
    else $error("frame did not clear the tick counter");

  // Without a frame the counter never goes down.
  a_ticks_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && acc && !evt.done) |=> (ticks_r >= $past(ticks_r)))
    else $error("tick counter decreased without a frame");

endmodule

>>> sim/tb_command_frame_receiver_watchdog.sv
// Self-checking testbench for the command frame receiver with tick watchdog.
module tb_command_frame_receiver_watchdog;
  import cfrw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;
  localparam int DRIBBLE_INDEX = DRIBBLE_INDEX_DEF;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 485;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  command_frame_receiver_watchdog #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .DRIBBLE_INDEX(DRIBBLE_INDEX)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Register copies held by the predictor.
  logic [7:0]  reg_first_hdr   = FIRST_HDR_RST;
  logic [7:0]  reg_second_hdr  = SECOND_HDR_RST;
  logic [7:0]  reg_dribble_on  = DRIBBLE_ON_RST;
  logic [15:0] reg_timeout_lim = TIMEOUT_LIM_RST;
  logic [14:0] reg_dribble_spd = DRIBBLE_SPD_RST;

  // Parser and watchdog state of the predictor.
  phase_t      mdl_phase   = PH_HUNT;
  logic [3:0]  mdl_count   = '0;
  logic [7:0]  mdl_store   [16];
  logic [15:0] mdl_targets [4];
  logic        mdl_dribble = 1'b0;
  logic [15:0] mdl_ticks   = '0;

  out_item_t   expected_results[$];
  int          err_count      = 0;
  int          items_sent     = 0;
  int          frames_seen    = 0;
  int          timeouts_seen  = 0;
  int          cycle_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  int          hold_request   = 0;

  initial begin
    foreach (mdl_store[i]) mdl_store[i] = '0;
    foreach (mdl_targets[i]) mdl_targets[i] = '0;
  end

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle counter and run limit.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
             expected_results.size());
    $display("TB_ERROR");
    $finish;
  end

  // Compute the result of one accepted input transfer and queue it.
  task automatic predict_item(input in_item_t txn);
    out_item_t r;
    logic      done;
    logic      expired;
    done = 1'b0;
    if (txn.action == ACT_TICK) begin
      if (mdl_ticks != TICK_MAX) mdl_ticks = mdl_ticks + 16'd1;
    end else begin
      case (mdl_phase)
        PH_HDR2: begin
          if (txn.rx_data == reg_second_hdr) begin
            mdl_phase = PH_BODY;
            mdl_count = '0;
          end else begin
            mdl_phase = PH_HUNT;
          end
        end
        PH_BODY: begin
          mdl_store[mdl_count] = txn.rx_data;
          if (int'(mdl_count) + 1 >= PAYLOAD_BYTES) begin
            // Frame complete: big-endian pairs become the wheel targets.
            for (int k = 0; k < 4; k++) begin
              mdl_targets[k] = {mdl_store[(2 * k) & 15], mdl_store[(2 * k + 1) & 15]};
            end
            mdl_dribble = (mdl_store[DRIBBLE_INDEX & 15] == reg_dribble_on);
            mdl_ticks   = '0;
            foreach (mdl_store[i]) mdl_store[i] = '0;
            mdl_phase   = PH_HUNT;
            mdl_count   = '0;
            done        = 1'b1;
          end else begin
            mdl_count = mdl_count + 4'd1;
          end
        end
        default: begin
          mdl_phase = (txn.rx_data == reg_first_hdr) ? PH_HDR2 : PH_HUNT;
        end
      endcase
    end
    // The watchdog is checked on every item.
    expired = (mdl_ticks >= reg_timeout_lim);
    if (expired) begin
      foreach (mdl_targets[i]) mdl_targets[i] = '0;
    end
    r.wheel_target_a = mdl_targets[0];
    r.wheel_target_b = mdl_targets[1];
    r.wheel_target_c = mdl_targets[2];
    r.wheel_target_d = mdl_targets[3];
    r.dribble_output = mdl_dribble ? reg_dribble_spd : 15'd0;
    r.frame_done     = done;
    r.timed_out      = expired;
    expected_results.push_back(r);
    items_sent++;
  endtask

  // Offer one input transfer; returns at the edge where it is accepted.
  task automatic send_item(input in_item_t txn);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= txn;
    do @(posedge clk); while (!in_ready);
    predict_item(txn);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t txn;
    txn.action  = ACT_BYTE;
    txn.rx_data = b;
    send_item(txn);
  endtask

  task automatic send_tick();
    in_item_t txn;
    // The data field is don't-care on a tick, so it carries random bits.
    txn.action  = ACT_TICK;
    txn.rx_data = 8'($urandom_range(255));
    send_item(txn);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Drop valid and wait until every expected result has been drained.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Register write followed by a read-back check, both while the block is idle.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] stored;
    wait_idle();
    case (idx)
      REG_FIRST_HDR:   stored = {24'd0, value[7:0]};
      REG_SECOND_HDR:  stored = {24'd0, value[7:0]};
      REG_DRIBBLE_ON:  stored = {24'd0, value[7:0]};
      REG_TIMEOUT_LIM: stored = {16'd0, value[15:0]};
      default:         stored = {17'd0, value[14:0]};
    endcase
    // Setup and access phases of the write.
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_FIRST_HDR:   reg_first_hdr   = stored[7:0];
      REG_SECOND_HDR:  reg_second_hdr  = stored[7:0];
      REG_DRIBBLE_ON:  reg_dribble_on  = stored[7:0];
      REG_TIMEOUT_LIM: reg_timeout_lim = stored[15:0];
      default:         reg_dribble_spd = stored[14:0];
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    // Read the register back.
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== stored) begin
      $error("register %0d read back: expected %0h, actual %0h", idx, stored, cfg_prdata);
      err_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // A well-formed frame with random content and occasional ticks mixed in.
  task automatic send_frame(input int tick_pct);
    logic [7:0] b;
    send_byte(reg_first_hdr);
    if ($urandom_range(99) < tick_pct) send_tick();
    send_byte(reg_second_hdr);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if ($urandom_range(99) < tick_pct) send_tick();
      if (i == DRIBBLE_INDEX && $urandom_range(1) == 1) b = reg_dribble_on;
      else b = rand_byte();
      send_byte(b);
    end
  endtask

  task automatic set_random_config();
    logic [15:0] lim;
    logic [14:0] spd;
    case ($urandom_range(3))
      0:       lim = 16'($urandom_range(1, 8));
      1:       lim = 16'($urandom_range(9, 40));
      2:       lim = 16'($urandom_range(1, 65535));
      default: lim = 16'hFFFF;
    endcase
    case ($urandom_range(2))
      0:       spd = 15'h7FFF;
      1:       spd = 15'd0;
      default: spd = 15'($urandom_range(32767));
    endcase
    write_reg(REG_FIRST_HDR, 32'(rand_byte()));
    write_reg(REG_SECOND_HDR, 32'(rand_byte()));
    write_reg(REG_DRIBBLE_ON, 32'(rand_byte()));
    write_reg(REG_TIMEOUT_LIM, 32'(lim));
    write_reg(REG_DRIBBLE_SPD, 32'(spd));
  endtask

  // Reset values: a frame with extreme targets and ticks inside the frame.
  task automatic test_default_frame();
    send_byte(8'h00);
    send_tick();
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_tick();
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h01);
  endtask

  // Header matching: stray bytes ignored, a wrong second header is discarded.
  task automatic test_header_rules();
    write_reg(REG_FIRST_HDR, 32'h0000_00FF);
    write_reg(REG_SECOND_HDR, 32'h0000_0000);
    write_reg(REG_DRIBBLE_ON, 32'h0000_00FF);
    write_reg(REG_DRIBBLE_SPD, 32'h0000_7FFF);
    send_byte(8'h37);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_tick();
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'hFF);
  endtask

  // Watchdog: smallest limit, a limit moved under a running count, and a
  // timeout that leaves the dribble flag alone.
  task automatic test_timeout_rules();
    write_reg(REG_TIMEOUT_LIM, 32'd1);
    send_tick();
    write_reg(REG_TIMEOUT_LIM, 32'd3);
    send_byte(8'h37);
    send_tick();
    send_tick();
    write_reg(REG_TIMEOUT_LIM, 32'd2);
    write_reg(REG_DRIBBLE_SPD, 32'd0);
    write_reg(REG_DRIBBLE_ON, 32'd0);
    send_byte(8'h55);
  endtask

  // Mostly well-formed frames, with tick bursts, broken headers and noise.
  task automatic run_random(input int count, input int spct, input int rpct);
    int         start;
    int         sel;
    int         burst;
    logic [7:0] b;
    set_random_config();
    send_idle_pct = spct;
    recv_idle_pct = rpct;
    start = items_sent;
    while (items_sent - start < count) begin
      sel = $urandom_range(99);
      if (sel < 65) begin
        send_frame(10);
      end else if (sel < 80) begin
        burst = (reg_timeout_lim <= 40) ? $urandom_range(1, int'(reg_timeout_lim) + 2)
                                        : $urandom_range(1, 6);
        repeat (burst) send_tick();
      end else if (sel < 90) begin
        send_byte(reg_first_hdr);
        b = rand_byte();
        if (b == reg_second_hdr) b = b ^ 8'h01;
        send_byte(b);
      end else if (sel < 95) begin
        send_byte(reg_first_hdr);
        send_byte(reg_second_hdr);
        repeat ($urandom_range(1, PAYLOAD_BYTES - 1)) send_byte(rand_byte());
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // The receiver holds off long enough for the input side to stall.
  task automatic test_backpressure();
    write_reg(REG_TIMEOUT_LIM, 32'd65535);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 400;
    repeat (5) send_frame(10);
  endtask

  // Result side: random or held-off out_ready, driven at the falling edge.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // Each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no expectation waiting");
        err_count++;
      end else begin
        exp_r = expected_results.pop_front();
        compare_field("wheel_target_a", int'(exp_r.wheel_target_a), int'(out_data.wheel_target_a));
        compare_field("wheel_target_b", int'(exp_r.wheel_target_b), int'(out_data.wheel_target_b));
        compare_field("wheel_target_c", int'(exp_r.wheel_target_c), int'(out_data.wheel_target_c));
        compare_field("wheel_target_d", int'(exp_r.wheel_target_d), int'(out_data.wheel_target_d));
        compare_field("dribble_output", int'(exp_r.dribble_output), int'(out_data.dribble_output));
        compare_field("frame_done", int'(exp_r.frame_done), int'(out_data.frame_done));
        compare_field("timed_out", int'(exp_r.timed_out), int'(out_data.timed_out));
        if (exp_r.frame_done) frames_seen++;
        if (exp_r.timed_out) timeouts_seen++;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_frame();
    test_header_rules();
    test_timeout_rules();
    run_random(RANDOM_ITEMS, 7, 87);
    run_random(RANDOM_ITEMS, 87, 7);
    run_random(RANDOM_ITEMS, 0, 0);
    test_backpressure();

    wait_idle();
    repeat (5) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      err_count++;
    end
    $display("Covered %0d input transfers: %0d completed frames, %0d timed-out results.",
             items_sent, frames_seen, timeouts_seen);
    $display("Header rules, watchdog limits, idle patterns and output stalls exercised.");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cfrw_pkg.sv
rtl/cfrw_parser.sv
rtl/command_frame_receiver_watchdog.sv
sim/tb_command_frame_receiver_watchdog.sv
